@@ rtl/vector2_magnitude_direction_unit_assert.svh @@
// Assertion macros shared by vmd_queue and vmd_back.
`ifndef VECTOR2_MAGNITUDE_DIRECTION_UNIT_ASSERT_SVH
`define VECTOR2_MAGNITUDE_DIRECTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vmd assertion failed");

// Next-cycle implication, checked out of reset.
`define VMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmd assertion failed");

`endif

@@ rtl/vmd_pkg.sv @@
package vmd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_W     = 64;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1) + 1;
  localparam logic [16:0] UNIT_ONE = 17'(1) << FRAC_BITS;

  // One classified vector waiting for the back end
  typedef struct packed {
    logic [63:0] sum_sq;
    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic        neg_x;
    logic        neg_y;
    logic        zero;
  } vmd_item_t;

  // Divide request and response
  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } vmd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } vmd_div_rsp_t;

endpackage

@@ rtl/vector2_magnitude_direction_unit.sv @@
// Vector magnitude and direction unit.
// Request: pulse start with in_comp_x / in_comp_y (signed Q16.16) while busy
// is low; the request is taken at that clock edge.
// Result: out_valid is high for exactly one cycle with out_magnitude
// (unsigned Q16.16, saturated), out_unit_x / out_unit_y (signed Q1.16) and
// out_zero_vector. The receiver cannot stall; results leave in request order.
// A front end takes the absolute values and squares in two stages and parks
// each vector in a four-entry queue, so requests keep being taken while the
// back end works. busy rises when the queue plus the front stages are full.
// The back end shares one radix-2 divider (one quotient bit per cycle)
// across HERON_STEPS root divisions and two unit divisions for each
// non-zero vector, and works on one vector at a time; a zero vector
// skips the divider and takes its result straight from the queue head.
// Reset (synchronous, rst_n low) empties the queue and stops any divide.
module vector2_magnitude_direction_unit #(
  parameter int HERON_STEPS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_comp_x,
  input  logic signed [31:0] in_comp_y,
  output logic               out_valid,
  output logic [31:0]        out_magnitude,
  output logic signed [17:0] out_unit_x,
  output logic signed [17:0] out_unit_y,
  output logic               out_zero_vector
);
  import vmd_pkg::*;

  logic              accept;
  logic [1:0]        in_flight;
  logic              push, pop, q_empty;
  vmd_item_t         push_item, head;
  logic [QCNT_W-1:0] q_count;

  // Hold off requests that could not find a queue slot
  assign busy   = (q_count + QCNT_W'(in_flight)) >= QCNT_W'(QDEPTH);
  assign accept = start && !busy;

  vmd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .comp_x   (in_comp_x),
    .comp_y   (in_comp_y),
    .in_flight(in_flight),
    .push     (push),
    .item     (push_item)
  );

  vmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head),
    .count    (q_count)
  );

  vmd_back #(
    .HERON_STEPS(HERON_STEPS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_magnitude  (out_magnitude),
    .out_unit_x     (out_unit_x),
    .out_unit_y     (out_unit_y),
    .out_zero_vector(out_zero_vector)
  );

endmodule

@@ rtl/vmd_front.sv @@
module vmd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [31:0]       comp_x,
  input  logic [31:0]       comp_y,
  output logic [1:0]        in_flight,
  output logic              push,
  output vmd_pkg::vmd_item_t item
);
  import vmd_pkg::*;

  logic        v1_r, v2_r;
  logic [31:0] ax1_r, ay1_r;
  logic        nx1_r, ny1_r;
  logic [63:0] sqx2_r, sqy2_r;
  logic [31:0] ax2_r, ay2_r;
  logic        nx2_r, ny2_r;

  // Track valid stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  // Take magnitudes and signs of the request
  always_ff @(posedge clk) begin
    nx1_r <= comp_x[31];
    ny1_r <= comp_y[31];
    ax1_r <= comp_x[31] ? (~comp_x + 32'd1) : comp_x;
    ay1_r <= comp_y[31] ? (~comp_y + 32'd1) : comp_y;
  end

  // Square each component
  always_ff @(posedge clk) begin
    sqx2_r <= 64'(ax1_r) * 64'(ax1_r);
    sqy2_r <= 64'(ay1_r) * 64'(ay1_r);
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    nx2_r  <= nx1_r;
    ny2_r  <= ny1_r;
  end

  // Sum and classify
  always_comb begin
    item.sum_sq = sqx2_r + sqy2_r;
    item.abs_x  = ax2_r;
    item.abs_y  = ay2_r;
    item.neg_x  = nx2_r;
    item.neg_y  = ny2_r;
    item.zero   = (ax2_r == 32'd0) && (ay2_r == 32'd0);
  end

  assign push      = v2_r;
  assign in_flight = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

@@ rtl/vmd_queue.sv @@
`include "vector2_magnitude_direction_unit_assert.svh"

module vmd_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  vmd_pkg::vmd_item_t        push_item,
  input  logic                      pop,
  output logic                      empty,
  output vmd_pkg::vmd_item_t        head,
  output logic [vmd_pkg::QCNT_W-1:0] count
);
  import vmd_pkg::*;

  vmd_item_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];
  assign count = cnt_r;

  `VMD_ASSERT_NOW(a_no_overflow, clk, rst_n, push && !pop, cnt_r < QCNT_W'(QDEPTH))
  `VMD_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, cnt_r != '0)

endmodule

@@ rtl/vmd_div.sv @@
module vmd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vmd_pkg::vmd_div_req_t req,
  output vmd_pkg::vmd_div_rsp_t rsp
);
  import vmd_pkg::*;

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r, quo_r, dsr_r;
  logic             done_r;
  logic [DIV_W-1:0] res_r;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    ge     = (rem_sh >= {1'b0, dsr_r});
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        res_r <= {quo_r[DIV_W-2:0], ge};
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = res_r;

endmodule

@@ rtl/vmd_back.sv @@
`include "vector2_magnitude_direction_unit_assert.svh"

module vmd_back #(
  parameter int HERON_STEPS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vmd_pkg::vmd_item_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  output logic [31:0]         out_magnitude,
  output logic signed [17:0]  out_unit_x,
  output logic signed [17:0]  out_unit_y,
  output logic                out_zero_vector
);
  import vmd_pkg::*;

  localparam int STEP_W = $clog2(HERON_STEPS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_UX   = 2'd2;
  localparam logic [1:0] ST_UY   = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  vmd_item_t         it_r;
  logic [63:0]       root_r, root_nxt;
  logic signed [17:0] ux_r, ux_nxt;
  vmd_div_req_t      req_r, req_nxt;
  vmd_div_rsp_t      rsp;
  logic              ov_r, ov_nxt;
  logic [31:0]       om_r, om_nxt;
  logic signed [17:0] oux_r, oux_nxt, ouy_r, ouy_nxt;
  logic              oz_r, oz_nxt;
  logic [64:0]       root_sum;
  logic [63:0]       root_new;
  logic [16:0]       q_sat;
  logic signed [17:0] u_pos, u_val;
  logic              cur_neg;

  vmd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req_r),
    .rsp  (rsp)
  );

  // Heron update and unit saturation
  always_comb begin
    root_sum = {1'b0, root_r} + {1'b0, rsp.quotient};
    root_new = root_sum[64:1];
    q_sat    = (rsp.quotient > 64'(UNIT_ONE)) ? UNIT_ONE : rsp.quotient[16:0];
    u_pos    = $signed({1'b0, q_sat});
    cur_neg  = (st_r == ST_UX) ? it_r.neg_x : it_r.neg_y;
    u_val    = cur_neg ? -u_pos : u_pos;
  end

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    root_nxt = root_r;
    ux_nxt   = ux_r;
    req_nxt  = '0;
    ov_nxt   = 1'b0;
    om_nxt   = om_r;
    oux_nxt  = oux_r;
    ouy_nxt  = ouy_r;
    oz_nxt   = oz_r;
    q_pop    = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.zero) begin
            ov_nxt  = 1'b1;
            om_nxt  = '0;
            oux_nxt = '0;
            ouy_nxt = '0;
            oz_nxt  = 1'b1;
          end else begin
            req_nxt.go       = 1'b1;
            req_nxt.dividend = q_head.sum_sq;
            req_nxt.divisor  = 64'(1) << FRAC_BITS;
            root_nxt         = 64'(1) << FRAC_BITS;
            step_nxt         = '0;
            st_nxt           = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (rsp.done) begin
          root_nxt       = root_new;
          req_nxt.go     = 1'b1;
          req_nxt.divisor = root_new;
          if (step_r == STEP_W'(HERON_STEPS - 1)) begin
            req_nxt.dividend = 64'(it_r.abs_x) << FRAC_BITS;
            st_nxt           = ST_UX;
          end else begin
            req_nxt.dividend = it_r.sum_sq;
            step_nxt         = step_r + STEP_W'(1);
          end
        end
      end
      ST_UX: begin
        if (rsp.done) begin
          ux_nxt           = u_val;
          req_nxt.go       = 1'b1;
          req_nxt.dividend = 64'(it_r.abs_y) << FRAC_BITS;
          req_nxt.divisor  = root_r;
          st_nxt           = ST_UY;
        end
      end
      ST_UY: begin
        if (rsp.done) begin
          ov_nxt  = 1'b1;
          om_nxt  = (root_r[63:32] != '0) ? 32'hFFFF_FFFF : root_r[31:0];
          oux_nxt = ux_r;
          ouy_nxt = u_val;
          oz_nxt  = 1'b0;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers and divide request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      ov_r      <= 1'b0;
      req_r.go  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      ov_r      <= ov_nxt;
      req_r.go  <= req_nxt.go;
    end
    req_r.dividend <= req_nxt.dividend;
    req_r.divisor  <= req_nxt.divisor;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r <= q_head;
    end
    step_r         <= step_nxt;
    root_r         <= root_nxt;
    ux_r           <= ux_nxt;
    om_r           <= om_nxt;
    oux_r          <= oux_nxt;
    ouy_r          <= ouy_nxt;
    oz_r           <= oz_nxt;
  end

  assign out_valid       = ov_r;
  assign out_magnitude   = om_r;
  assign out_unit_x      = oux_r;
  assign out_unit_y      = ouy_r;
  assign out_zero_vector = oz_r;

  `VMD_ASSERT_NOW(a_done_when_busy, clk, rst_n, rsp.done, st_r != ST_IDLE)
  `VMD_ASSERT_NOW(a_zero_outputs, clk, rst_n, ov_r && oz_r, om_r == '0 && oux_r == '0 && ouy_r == '0)
  `VMD_ASSERT_NEXT(a_pop_nonzero_starts, clk, rst_n, q_pop && !q_head.zero, st_r == ST_ROOT && req_r.go)

endmodule

@@ dv/vector2_magnitude_direction_checker.sv @@
module vector2_magnitude_direction_checker
  import vmd_pkg::*;
#(
  parameter int HERON_STEPS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_comp_x,
  input  logic signed [31:0] in_comp_y,
  input  logic               out_valid,
  input  logic [31:0]        out_magnitude,
  input  logic signed [17:0] out_unit_x,
  input  logic signed [17:0] out_unit_y,
  input  logic               out_zero_vector,
  output int                 mismatch_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 zero_result_count,
  output int                 saturated_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] magnitude;
    logic [17:0] unit_x;
    logic [17:0] unit_y;
    logic        zero_vector;
  } direction_t;

  direction_t expected_directions[$];

  // Scale one absolute component by the root, clamp to 1.0, apply the sign
  function automatic logic [17:0] unit_component(longint unsigned abs_val, bit neg,
                                                 longint unsigned root);
    longint unsigned one;
    longint unsigned quot;
    one  = 64'd1 << FRAC_BITS;
    quot = (root == 0) ? one : (abs_val << FRAC_BITS) / root;
    if (quot > one) begin
      quot = one;
    end
    if (neg) begin
      quot = 64'd0 - quot;
    end
    return quot[17:0];
  endfunction

  // Sum of squares, fixed Heron root from 1.0, then the direction
  function automatic direction_t predict_direction(logic [31:0] x, logic [31:0] y);
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned sum_sq;
    longint unsigned root;
    direction_t      res;
    ax     = x[31] ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
    ay     = y[31] ? (64'd1 << 32) - {32'd0, y} : {32'd0, y};
    sum_sq = ax * ax + ay * ay;
    res    = '0;
    if (sum_sq == 0) begin
      res.zero_vector = 1'b1;
      return res;
    end
    root = 64'd1 << FRAC_BITS;
    for (int i = 0; i < HERON_STEPS; i++) begin
      if (root == 0) begin
        break;
      end
      root = (root + sum_sq / root) >> 1;
    end
    res.magnitude = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    res.unit_x    = unit_component(ax, x[31], root);
    res.unit_y    = unit_component(ay, y[31], root);
    return res;
  endfunction

  assign pending_count = expected_directions.size();

  initial begin
    mismatch_count    = 0;
    result_count      = 0;
    zero_result_count = 0;
    saturated_count   = 0;
  end

  // Predict on each taken request, compare each strobed result with the oldest one
  always @(posedge clk) begin
    direction_t want;
    direction_t got;
    if (rst_n) begin
      if (start && !busy) begin
        expected_directions.push_back(predict_direction(in_comp_x, in_comp_y));
      end
      if (out_valid) begin
        got = {out_magnitude, out_unit_x, out_unit_y, out_zero_vector};
        result_count++;
        if (expected_directions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] unexpected result: mag=%h ux=%h uy=%h zero=%b",
                     $realtime, got.magnitude, got.unit_x, got.unit_y, got.zero_vector);
          end
        end else begin
          want = expected_directions.pop_front();
          if (want.zero_vector) begin
            zero_result_count++;
          end
          if (want.unit_x == 18'h10000 || want.unit_x == 18'h30000 ||
              want.magnitude == 32'hFFFF_FFFF) begin
            saturated_count++;
          end
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] mismatch: mag exp=%h act=%h ux exp=%h act=%h uy exp=%h act=%h zero exp=%b act=%b",
                       $realtime, want.magnitude, got.magnitude, want.unit_x, got.unit_x,
                       want.unit_y, got.unit_y, want.zero_vector, got.zero_vector);
            end
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_vector2_magnitude_direction_unit.sv @@
module tb_vector2_magnitude_direction_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vmd_pkg::*;

  localparam int NUM_RANDOM     = 630;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_comp_x;
  logic signed [31:0] in_comp_y;
  logic               out_valid;
  logic [31:0]        out_magnitude;
  logic signed [17:0] out_unit_x;
  logic signed [17:0] out_unit_y;
  logic               out_zero_vector;

  int mismatch_count;
  int pending_count;
  int result_count;
  int zero_result_count;
  int saturated_count;
  int idle_cycles;
  int sent_count;

  vector2_magnitude_direction_unit #(.HERON_STEPS(20)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_comp_x      (in_comp_x),
    .in_comp_y      (in_comp_y),
    .out_valid      (out_valid),
    .out_magnitude  (out_magnitude),
    .out_unit_x     (out_unit_x),
    .out_unit_y     (out_unit_y),
    .out_zero_vector(out_zero_vector)
  );

  vector2_magnitude_direction_checker #(.HERON_STEPS(20)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_comp_x        (in_comp_x),
    .in_comp_y        (in_comp_y),
    .out_valid        (out_valid),
    .out_magnitude    (out_magnitude),
    .out_unit_x       (out_unit_x),
    .out_unit_y       (out_unit_y),
    .out_zero_vector  (out_zero_vector),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .result_count     (result_count),
    .zero_result_count(zero_result_count),
    .saturated_count  (saturated_count)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Count cycles with no request taken and no result, end the run on a hang
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request at the falling edge, hold it until taken
  task automatic send_vector(logic [31:0] x, logic [31:0] y, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start     = 1'b1;
    in_comp_x = x;
    in_comp_y = y;
    do begin
      @(posedge clk);
    end while (busy);
    sent_count++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Pick a random component from one of several value classes
  function automatic logic [31:0] rand_component(int kind);
    case (kind)
      0: return 32'd0;
      1: return $urandom();
      2: return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
      3: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(255)
                                  : 32'h7FFF_FFFF - $urandom_range(255);
      default: return 32'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  initial begin
    logic [31:0] rx;
    logic [31:0] ry;
    int          idle_pct;
    int          sel;
    idle_cycles = 0;
    sent_count  = 0;
    start       = 1'b0;
    in_comp_x   = '0;
    in_comp_y   = '0;
    rst_n       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: zero vector, extremes, unit axes, small and saturating cases
    send_vector(32'h0000_0000, 32'h0000_0000, 0);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 0);
    send_vector(32'h8000_0000, 32'h0000_0000, 0);
    send_vector(32'h0000_0000, 32'h8000_0000, 0);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_vector(32'h0000_0001, 32'h0000_0000, 0);
    send_vector(32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_vector(32'h0000_0001, 32'h0000_0001, 0);
    send_vector(32'h0001_0000, 32'h0000_0000, 0);
    send_vector(32'h0003_0000, 32'hFFFC_0000, 0);
    send_vector(32'hFFFF_0000, 32'h0001_0000, 0);
    send_vector(32'h0000_0000, 32'h0000_0000, 0);
    send_vector(32'h0000_0003, 32'h0000_0004, 0);
    send_vector(32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_vector(32'h0000_FFFF, 32'hFFFF_0001, 0);
    send_vector(32'h4000_0000, 32'hC000_0000, 0);

    // Random: three idle phases, with one full drain in the middle
    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_pct = (n < NUM_RANDOM / 3) ? 22 : (n < 2 * NUM_RANDOM / 3) ? 58 : 0;
      if (n == NUM_RANDOM / 2) begin
        while (pending_count != 0) begin
          @(negedge clk);
        end
      end
      sel = $urandom_range(99);
      if (sel < 10) begin
        rx = 32'd0;
        ry = 32'd0;
      end else if (sel < 20) begin
        rx = rand_component($urandom_range(4) == 0 ? 0 : 1);
        ry = ($urandom_range(1) == 0) ? 32'd0 : rand_component(2);
        if ($urandom_range(1)) begin
          {rx, ry} = {ry, rx};
        end
      end else begin
        rx = rand_component($urandom_range(1, 4));
        ry = rand_component($urandom_range(1, 4));
      end
      send_vector(rx, ry, idle_pct);
    end

    // Drain outstanding results, then allow the pipeline to settle
    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d vectors, checked %0d results (%0d zero, %0d saturated)",
             sent_count, result_count, zero_result_count, saturated_count);
    $display("idle phases 22%%/58%%/0%% on the request side, one full drain mid-run");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
